FILE: hdl/md5_pkg.sv
// md5 digest engine: shared types, queue sizing and the round constant tables
// no dependencies; imported by every module of the engine
package md5_pkg;

    // what one queued beat asks the back end to do
    typedef enum logic [1:0] {
        ITEM_DATA,       // four message bytes, more to follow
        ITEM_LAST_FULL,  // final word with four bytes, pad word still owed
        ITEM_LAST_PART   // final word already masked with the pad byte in place
    } item_kind_t;

    typedef struct packed {
        logic [31:0] word;
        item_kind_t  kind;
        logic [5:0]  bit_add;   // message bits carried by this beat, 0 to 32
    } md5_item_t;

    // back end sequencer
    typedef enum logic [2:0] {
        ST_LOAD,   // take words from the queue into the block buffer
        ST_PAD,    // generate pad, zero and length words
        ST_ROUND,  // one md5 round per cycle
        ST_ADD,    // fold working variables into the chaining value
        ST_OUT     // emit the four digest words
    } core_state_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = 3;

    localparam logic [31:0] PAD_WORD = 32'h0000_0080;

    localparam logic [31:0] IV_A = 32'h6745_2301;
    localparam logic [31:0] IV_B = 32'hefcd_ab89;
    localparam logic [31:0] IV_C = 32'h98ba_dcfe;
    localparam logic [31:0] IV_D = 32'h1032_5476;

    localparam logic [31:0] MD5_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // rotate amounts, indexed by {group, round[1:0]}
    localparam logic [4:0] MD5_ROT [16] = '{
        5'd7,  5'd12, 5'd17, 5'd22,
        5'd5,  5'd9,  5'd14, 5'd20,
        5'd4,  5'd11, 5'd16, 5'd23,
        5'd6,  5'd10, 5'd15, 5'd21
    };

    // message word used by a round
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] x;
        logic [3:0] g;
        x = rnd[3:0];
        unique case (rnd[5:4])
            2'd0:    g = x;
            2'd1:    g = (x << 2) + x + 4'd1;
            2'd2:    g = (x << 1) + x + 4'd5;
            default: g = (x << 3) - x;
        endcase
        return g;
    endfunction

endpackage

FILE: hdl/md5_front.sv
// md5 digest engine front end: accepts input beats and classifies them
// depends on md5_pkg; feeds md5_queue
module md5_front (
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [31:0]        s_axis_tdata,   // message_word
    input  logic               s_axis_tlast,   // final_word
    input  logic [2:0]         s_axis_tuser,   // valid_bytes
    output logic               item_valid,
    input  logic               item_ready,
    output md5_pkg::md5_item_t item
);
    import md5_pkg::*;

    logic [2:0]  nv;
    logic [31:0] mask;
    logic [4:0]  pad_shift;

    // valid byte count, five to seven count as four
    assign nv = s_axis_tuser[2] ? 3'd4 : s_axis_tuser;

    // keep only the valid bytes of a short final word
    always_comb
    begin
        case (nv[1:0])
            2'd0:    mask = 32'h0000_0000;
            2'd1:    mask = 32'h0000_00ff;
            2'd2:    mask = 32'h0000_ffff;
            default: mask = 32'h00ff_ffff;
        endcase
    end

    assign pad_shift = {nv[1:0], 3'b000};

    // classify the beat
    always_comb
    begin
        if (!s_axis_tlast)
        begin
            item.word    = s_axis_tdata;
            item.kind    = ITEM_DATA;
            item.bit_add = 6'd32;
        end
        else if (nv[2])
        begin
            item.word    = s_axis_tdata;
            item.kind    = ITEM_LAST_FULL;
            item.bit_add = 6'd32;
        end
        else
        begin
            item.word    = (s_axis_tdata & mask) | (PAD_WORD << pad_shift);
            item.kind    = ITEM_LAST_PART;
            item.bit_add = {1'b0, nv[1:0], 3'b000};
        end
    end

    assign item_valid    = s_axis_tvalid;
    assign s_axis_tready = item_ready;

endmodule

FILE: hdl/md5_queue.sv
// md5 digest engine item queue between front end and core
// depends on md5_pkg
module md5_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  md5_pkg::md5_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output md5_pkg::md5_item_t pop_item
);
    import md5_pkg::*;

    md5_item_t             mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]   count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

FILE: hdl/md5_core.sv
// md5 digest engine back end: block buffer, padding, rounds and digest output
// depends on md5_pkg; takes items from md5_queue
module md5_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  md5_pkg::md5_item_t item,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [31:0]        m_axis_tdata,   // digest_word
    output logic               m_axis_tlast,   // digest_last
    output logic [1:0]         m_axis_tuser    // digest_index
);
    import md5_pkg::*;

    core_state_t  state_reg, state_next;
    logic [31:0]  buffer [16];
    logic [3:0]   pos_reg, pos_next;
    logic [63:0]  count_reg, count_next;
    logic [5:0]   round_reg, round_next;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg;
    logic [31:0]  a_next, b_next, c_next, d_next;
    logic [31:0]  h0_reg, h1_reg, h2_reg, h3_reg;
    logic [31:0]  h0_next, h1_next, h2_next, h3_next;
    logic         tail_reg, tail_next;
    logic         need80_reg, need80_next;
    logic         lenlo_reg, lenlo_next;
    logic         done_reg, done_next;
    logic [1:0]   out_idx_reg, out_idx_next;
    logic         out_valid_reg, out_valid_next;
    logic [31:0]  out_word_reg, out_word_next;
    logic [1:0]   out_index_reg, out_index_next;
    logic         out_last_reg, out_last_next;

    logic         pop;
    logic         push_en;
    logic [31:0]  push_word;
    logic [31:0]  pad_word;
    logic         out_load;
    logic [31:0]  f_val;
    logic [31:0]  t_val;
    logic [31:0]  m_val;
    logic [63:0]  rot_wide;
    logic [31:0]  chain_sel;

    // handshake strobes
    assign item_ready = (state_reg == ST_LOAD);
    assign pop        = item_valid && item_ready;
    assign out_load   = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);

    // generated tail words: pad byte, zeros, then length low and high
    always_comb
    begin
        if (need80_reg)
            pad_word = PAD_WORD;
        else if (pos_reg == 4'd14)
            pad_word = count_reg[31:0];
        else if (pos_reg == 4'd15 && lenlo_reg)
            pad_word = count_reg[63:32];
        else
            pad_word = '0;
    end

    assign push_en   = pop || (state_reg == ST_PAD);
    assign push_word = (state_reg == ST_PAD) ? pad_word : item.word;

    // round function
    always_comb
    begin
        unique case (round_reg[5:4])
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f_val = (d_reg & b_reg) | (~d_reg & c_reg);
            2'd2:    f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
    end

    assign m_val    = buffer[msg_index(round_reg)];
    assign t_val    = a_reg + f_val + MD5_K[round_reg] + m_val;
    assign rot_wide = {t_val, t_val} << MD5_ROT[{round_reg[5:4], round_reg[1:0]}];

    // digest word select
    always_comb
    begin
        case (out_idx_reg)
            2'd0:    chain_sel = h0_reg;
            2'd1:    chain_sel = h1_reg;
            2'd2:    chain_sel = h2_reg;
            default: chain_sel = h3_reg;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (pop)
                begin
                    if (pos_reg == 4'd15)
                        state_next = ST_ROUND;
                    else if (item.kind != ITEM_DATA)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (pos_reg == 4'd15)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (round_reg == 6'd63)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (done_reg)
                    state_next = ST_OUT;
                else if (tail_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_LOAD;
            end
            ST_OUT:
            begin
                if (out_load && out_idx_reg == 2'd3)
                    state_next = ST_LOAD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // datapath and flag updates
    always_comb
    begin
        pos_next       = pos_reg;
        count_next     = count_reg;
        round_next     = round_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        h0_next        = h0_reg;
        h1_next        = h1_reg;
        h2_next        = h2_reg;
        h3_next        = h3_reg;
        tail_next      = tail_reg;
        need80_next    = need80_reg;
        lenlo_next     = lenlo_reg;
        done_next      = done_reg;
        out_idx_next   = out_idx_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_index_next = out_index_reg;
        out_last_next  = out_last_reg;

        // word into the block buffer
        if (push_en)
        begin
            pos_next = pos_reg + 1'b1;
            if (pos_reg == 4'd15)
            begin
                a_next     = h0_reg;
                b_next     = h1_reg;
                c_next     = h2_reg;
                d_next     = h3_reg;
                round_next = '0;
            end
        end

        // beat taken from the queue
        if (pop)
        begin
            count_next = count_reg + {58'd0, item.bit_add};
            if (item.kind != ITEM_DATA)
            begin
                tail_next   = 1'b1;
                need80_next = (item.kind == ITEM_LAST_FULL);
            end
        end

        // tail word bookkeeping
        if (state_reg == ST_PAD)
        begin
            need80_next = 1'b0;
            if (!need80_reg && pos_reg == 4'd14)
                lenlo_next = 1'b1;
            if (pos_reg == 4'd15 && lenlo_reg)
                done_next = 1'b1;
        end

        // one round
        if (state_reg == ST_ROUND)
        begin
            a_next     = d_reg;
            d_next     = c_reg;
            c_next     = b_reg;
            b_next     = b_reg + rot_wide[63:32];
            round_next = round_reg + 1'b1;
        end

        // chaining update
        if (state_reg == ST_ADD)
        begin
            h0_next = h0_reg + a_reg;
            h1_next = h1_reg + b_reg;
            h2_next = h2_reg + c_reg;
            h3_next = h3_reg + d_reg;
        end

        // output register
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_word_next  = chain_sel;
            out_index_next = out_idx_reg;
            out_last_next  = (out_idx_reg == 2'd3);
            out_idx_next   = out_idx_reg + 1'b1;
            if (out_idx_reg == 2'd3)
            begin
                h0_next    = IV_A;
                h1_next    = IV_B;
                h2_next    = IV_C;
                h3_next    = IV_D;
                count_next = '0;
                pos_next   = '0;
                tail_next  = 1'b0;
                lenlo_next = 1'b0;
                done_next  = 1'b0;
            end
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control and chaining registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            pos_reg       <= '0;
            count_reg     <= '0;
            round_reg     <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            c_reg         <= '0;
            d_reg         <= '0;
            h0_reg        <= IV_A;
            h1_reg        <= IV_B;
            h2_reg        <= IV_C;
            h3_reg        <= IV_D;
            tail_reg      <= 1'b0;
            need80_reg    <= 1'b0;
            lenlo_reg     <= 1'b0;
            done_reg      <= 1'b0;
            out_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            round_reg     <= round_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            c_reg         <= c_next;
            d_reg         <= d_next;
            h0_reg        <= h0_next;
            h1_reg        <= h1_next;
            h2_reg        <= h2_next;
            h3_reg        <= h3_next;
            tail_reg      <= tail_next;
            need80_reg    <= need80_next;
            lenlo_reg     <= lenlo_next;
            done_reg      <= done_next;
            out_idx_reg   <= out_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers and block buffer
    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        out_index_reg <= out_index_next;
        out_last_reg  <= out_last_next;
        if (push_en)
            buffer[pos_reg] <= push_word;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_word_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_index_reg;

endmodule

FILE: hdl/md5_digest_engine.sv
// md5 digest engine top level: front end, item queue and hashing core
// depends on md5_pkg, md5_front, md5_queue and md5_core
//
//   port group   dir   beat contents (low bits first)
//   s_axis       in    tdata message_word, tlast final_word, tuser valid_bytes
//   m_axis       out   tdata digest_word, tlast digest_last, tuser digest_index
//
// the core writes one word per cycle into the 16-word block buffer while the
// queue holds items, then runs the 64 rounds at one per cycle and adds into
// the chaining value; it takes no queue words until the 512-bit block is done.
// a final word adds pad and length words at one per cycle, possibly one more
// block, then four digest beats. reset clears control state; no clearing pass.
// the input stalls only when the four-entry item queue is full; the core
// stalls only while a digest beat waits on m_axis_tready or the queue is empty.
module md5_digest_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // message_word
    input  logic        s_axis_tlast,    // final_word
    input  logic [2:0]  s_axis_tuser,    // valid_bytes
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // digest_word
    output logic        m_axis_tlast,    // digest_last
    output logic [1:0]  m_axis_tuser     // digest_index
);
    import md5_pkg::*;

    md5_item_t front_item;
    logic      front_valid;
    logic      front_ready;
    md5_item_t core_item;
    logic      core_valid;
    logic      core_ready;

    md5_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .item_valid    (front_valid),
        .item_ready    (front_ready),
        .item          (front_item)
    );

    md5_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (core_valid),
        .pop_ready  (core_ready),
        .pop_item   (core_item)
    );

    md5_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (core_valid),
        .item_ready    (core_ready),
        .item          (core_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // digest beats come back to back in index order
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 2'd1))
        else $error("digest beat missing or out of order");

    // last flag only on the h3 beat
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 2'd3)))
        else $error("digest last flag does not match index");

    // a beat right after the last one starts a new digest at h0
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
        (!m_axis_tvalid || m_axis_tuser == 2'd0))
        else $error("digest beat after last is not h0");

endmodule

FILE: bench/tb.sv
// md5_digest_engine testbench: directed beats (two known digests), then random messages
// needs md5_digest_engine, its submodules and its package; prints one pass or fail line
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int RAND_ITEMS  = 127;
    localparam int QUIET_AFTER = 100;
    localparam int DRAIN_WAIT  = 200;

    // one digest beat as it should appear on the master side
    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  idx;
        logic        is_last;
    } digest_beat_t;

    // one directed input beat; digest holds h3..h0 with h0 in the low bits
    typedef struct packed {
        logic [31:0]  word;
        logic         is_last;
        logic [2:0]   nbytes;
        logic         known;
        logic [127:0] digest;
    } dir_row_t;

    localparam logic [127:0] EMPTY_DIGEST = 128'h7e42f8ec_980980e9_04b2008f_d98c1dd4;
    localparam logic [127:0] ABC_DIGEST   = 128'h727fe128_7d3f96d6_b04fd23c_98500190;

    localparam int DIR_ROWS = 23;
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        // empty message, stray bytes in the final word must be dropped
        '{32'hffff_ffff, 1'b1, 3'd0, 1'b1, EMPTY_DIGEST},
        // "abc" with a junk top byte
        '{32'hff63_6261, 1'b1, 3'd3, 1'b1, ABC_DIGEST},
        '{32'h0000_0000, 1'b1, 3'd1, 1'b0, 128'h0},
        '{32'hffff_ffff, 1'b1, 3'd2, 1'b0, 128'h0},
        '{32'hffff_ffff, 1'b1, 3'd4, 1'b0, 128'h0},
        // byte counts above four act as four
        '{32'h1234_5678, 1'b1, 3'd7, 1'b0, 128'h0},
        '{32'hdead_beef, 1'b1, 3'd5, 1'b0, 128'h0},
        // short count on a word that is not final is ignored
        '{32'h0000_0000, 1'b0, 3'd1, 1'b0, 128'h0},
        '{32'hffff_ffff, 1'b1, 3'd6, 1'b0, 128'h0},
        // fourteen full words, pad spills into a second block
        '{32'hffff_ffff, 1'b0, 3'd0, 1'b0, 128'h0},
        '{32'h0000_0000, 1'b0, 3'd7, 1'b0, 128'h0},
        '{32'hffff_ffff, 1'b0, 3'd2, 1'b0, 128'h0},
        '{32'h0000_0000, 1'b0, 3'd5, 1'b0, 128'h0},
        '{32'h0123_4567, 1'b0, 3'd4, 1'b0, 128'h0},
        '{32'h89ab_cdef, 1'b0, 3'd3, 1'b0, 128'h0},
        '{32'hffff_ffff, 1'b0, 3'd1, 1'b0, 128'h0},
        '{32'h0000_0000, 1'b0, 3'd6, 1'b0, 128'h0},
        '{32'h8000_0001, 1'b0, 3'd0, 1'b0, 128'h0},
        '{32'h7fff_fffe, 1'b0, 3'd7, 1'b0, 128'h0},
        '{32'hffff_ffff, 1'b0, 3'd4, 1'b0, 128'h0},
        '{32'h0000_0000, 1'b0, 3'd2, 1'b0, 128'h0},
        '{32'h5a5a_a5a5, 1'b0, 3'd1, 1'b0, 128'h0},
        '{32'ha5a5_5a5a, 1'b1, 3'd4, 1'b0, 128'h0}
    };

    // md5 additive constants and rotate amounts
    localparam logic [31:0] RND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    localparam int RND_ROT [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                    4, 11, 16, 23, 6, 10, 15, 21};
    localparam logic [31:0] INIT_CHAIN [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_tdata = 32'h0;
    logic        s_tlast = 1'b0;
    logic [2:0]  s_tuser = 3'd0;
    logic        m_axis_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;

    // stimulus to receiver controls
    logic hold_req = 1'b0;
    logic quiet = 1'b0;

    // predictor state
    logic [31:0] chain_h [4];
    logic [31:0] blk_words [16];
    logic [3:0]  blk_pos;
    logic [63:0] msg_bits;

    digest_beat_t digest_q [$];
    int mismatch_count = 0;
    int cycle_count = 0;

    md5_digest_engine u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock and reset
    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("md5_digest_engine test failed");
        $finish;
    end

    // 64 rounds over the block, folded into the chaining value
    task automatic md5_compress();
        logic [31:0] a, b, c, d, f, t;
        int g;
        int grp;
        int r;
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        for (int i = 0; i < 64; i++)
        begin
            grp = i >> 4;
            case (grp)
                0:
                begin
                    f = (b & c) | (~b & d);
                    g = i;
                end
                1:
                begin
                    f = (d & b) | (~d & c);
                    g = (5 * i + 1) & 15;
                end
                2:
                begin
                    f = b ^ c ^ d;
                    g = (3 * i + 5) & 15;
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    g = (7 * i) & 15;
                end
            endcase
            t = a + f + RND_K[i] + blk_words[g];
            r = RND_ROT[(grp << 2) | (i & 3)];
            a = d;
            d = c;
            c = b;
            b = b + ((t << r) | (t >> (32 - r)));
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
    endtask

    task automatic md5_absorb_word(input logic [31:0] w);
        blk_words[blk_pos] = w;
        blk_pos = blk_pos + 4'd1;
        if (blk_pos == 4'd0)
            md5_compress();
    endtask

    task automatic md5_restart();
        for (int k = 0; k < 4; k++)
            chain_h[k] = INIT_CHAIN[k];
        blk_pos = 4'd0;
        msg_bits = 64'd0;
    endtask

    // one accepted input beat; on a final beat pad, add length and give the digest
    task automatic md5_take_beat(input logic [31:0] w, input logic is_last,
                                 input logic [2:0] nb, output logic done,
                                 output logic [127:0] dig);
        int n;
        logic [31:0] mask;
        logic [63:0] bits;
        done = 1'b0;
        dig = 128'h0;
        if (!is_last)
        begin
            msg_bits += 64'd32;
            md5_absorb_word(w);
        end
        else
        begin
            n = (nb > 3'd4) ? 4 : int'(nb);
            msg_bits += 64'(8 * n);
            bits = msg_bits;
            if (n == 4)
            begin
                md5_absorb_word(w);
                md5_absorb_word(32'h0000_0080);
            end
            else
            begin
                mask = (n == 0) ? 32'h0 : (32'hffff_ffff >> (32 - 8 * n));
                md5_absorb_word((w & mask) | (32'h0000_0080 << (8 * n)));
            end
            while (blk_pos != 4'd14)
                md5_absorb_word(32'h0);
            md5_absorb_word(bits[31:0]);
            md5_absorb_word(bits[63:32]);
            dig = {chain_h[3], chain_h[2], chain_h[1], chain_h[0]};
            done = 1'b1;
            md5_restart();
        end
    endtask

    // offer one beat, wait for the handshake, then record what it should cause
    task automatic send_beat(input logic [31:0] w, input logic is_last, input logic [2:0] nb,
                             input logic known, input logic [127:0] known_dig);
        logic done;
        logic [127:0] dig;
        digest_beat_t exp_beat;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tlast  <= is_last;
        s_tuser  <= nb;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        md5_take_beat(w, is_last, nb, done, dig);
        if (done)
        begin
            if (known)
                dig = known_dig;
            for (int k = 0; k < 4; k++)
            begin
                exp_beat.word    = dig[32 * k +: 32];
                exp_beat.idx     = 2'(k);
                exp_beat.is_last = (k == 3);
                digest_q.push_back(exp_beat);
            end
        end
    endtask

    function automatic logic [31:0] rand_word();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 32'h0;
        if (r == 1)
            return 32'hffff_ffff;
        return $urandom;
    endfunction

    // receiver: random short stalls, one long hold on request
    initial
    begin
        logic hold_done;
        hold_done = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // compare each digest beat with the oldest expectation
    always @(posedge clk)
    begin
        digest_beat_t exp_beat;
        if (rst_n && m_axis_tvalid && m_tready)
        begin
            if (digest_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected digest beat: word %h idx %0d last %b",
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            else
            begin
                exp_beat = digest_q.pop_front();
                if (m_axis_tdata !== exp_beat.word || m_axis_tuser !== exp_beat.idx
                    || m_axis_tlast !== exp_beat.is_last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("digest mismatch: exp word %h idx %0d last %b, got %h %0d %b",
                                 exp_beat.word, exp_beat.idx, exp_beat.is_last,
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int n_items;
        int len;
        int r;
        n_items = 0;
        md5_restart();
        for (int k = 0; k < 16; k++)
            blk_words[k] = 32'h0;
        wait (rst_n);
        @(posedge clk);

        // directed table
        for (int i = 0; i < DIR_ROWS; i++)
            send_beat(DIR_TAB[i].word, DIR_TAB[i].is_last, DIR_TAB[i].nbytes,
                      DIR_TAB[i].known, DIR_TAB[i].digest);

        // sender pause until every digest beat is back
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (digest_q.size() != 0);

        // long receiver hold while messages keep coming, so the queue backs up
        hold_req <= 1'b1;
        len = 1;
        while (n_items < RAND_ITEMS)
        begin
            for (int j = 0; j < len; j++)
            begin
                send_beat(rand_word(), 1'b0, 3'($urandom_range(0, 7)), 1'b0, 128'h0);
                n_items++;
                if (n_items >= QUIET_AFTER)
                    quiet <= 1'b1;
            end
            send_beat(rand_word(), 1'b1, 3'($urandom_range(0, 7)), 1'b0, 128'h0);
            n_items++;
            if (n_items >= QUIET_AFTER)
                quiet <= 1'b1;
            // mostly short messages, some around the pad boundary, a few long
            r = $urandom_range(0, 9);
            if (r < 6)
                len = $urandom_range(0, 11);
            else if (r < 9)
                len = $urandom_range(12, 18);
            else
                len = $urandom_range(19, 40);
            // last message ends at the planned item count
            if (len > RAND_ITEMS - n_items - 1)
                len = (RAND_ITEMS - n_items - 1 > 0) ? RAND_ITEMS - n_items - 1 : 0;
        end
        s_tvalid <= 1'b0;

        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0)
            $display("md5_digest_engine test passed");
        else
            $display("md5_digest_engine test failed");
        $finish;
    end

endmodule

FILE: sim.f
hdl/md5_pkg.sv
hdl/md5_front.sv
hdl/md5_queue.sv
hdl/md5_core.sv
hdl/md5_digest_engine.sv
bench/tb.sv
